@@ sv/cbs_pkg.sv @@
package cbs_pkg;

  localparam int CoordW       = 10;
  localparam int OutW         = 18;
  localparam int IdxW         = 5;
  localparam int WFrac        = 16;
  localparam int OShift       = 8;
  localparam int WeightW      = WFrac + 1;
  localparam int ProdW        = CoordW + WeightW + 1;
  localparam int SumW         = ProdW + 2;
  localparam int RoundW       = SumW - OShift;
  localparam int NumPts       = 4;
  localparam int StepsDefault = 20;
  localparam int QueueDepth   = 2;
  localparam int QPtrW        = $clog2(QueueDepth);
  localparam int QCntW        = $clog2(QueueDepth + 1);

  localparam logic signed [RoundW-1:0] OutMax = RoundW'((1 << (OutW - 1)) - 1);
  localparam logic signed [RoundW-1:0] OutMin = -RoundW'(1 << (OutW - 1));
  localparam logic signed [SumW-1:0]   RoundHalf = SumW'(1 << (WFrac - OShift - 1));

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } pts_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ sv/cbs_queue.sv @@
module cbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbs_pkg::pts_t din,
  input  logic          pop,
  output cbs_pkg::pts_t dout,
  output cbs_pkg::qstat_t stat
);
  import cbs_pkg::*;

  pts_t             mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign stat.full  = (count == QCntW'(QueueDepth));
  assign stat.empty = (count == '0);
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/cbs_back.sv @@
module cbs_back #(
  parameter int STEPS = cbs_pkg::StepsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cbs_pkg::pts_t                      head,
  input  cbs_pkg::qstat_t                    stat,
  output logic                               pop,
  output logic                               valid,
  output logic signed [cbs_pkg::OutW-1:0]    curve_x,
  output logic signed [cbs_pkg::OutW-1:0]    curve_y,
  output logic        [cbs_pkg::IdxW-1:0]    sample_index,
  output logic                               last_sample
);
  import cbs_pkg::*;

  localparam int    CntW = (STEPS > 2) ? $clog2(STEPS) : 1;
  localparam longint Den = longint'(STEPS) * longint'(STEPS) * longint'(STEPS);

  // Bernstein weight k at sample i, 16 fraction bits, round half up.
  function automatic logic [WeightW-1:0] bern(int i, int k);
    longint num;
    num = ((k == 0) || (k == 3)) ? 64'sd1 : 64'sd3;
    for (int j = 0; j < k; j++) begin
      num = num * longint'(i);
    end
    for (int j = k; j < 3; j++) begin
      num = num * longint'(STEPS - i);
    end
    return WeightW'(((num << WFrac) + Den / 2) / Den);
  endfunction

  logic [WeightW-1:0] wtab [STEPS][NumPts];

  for (genvar g = 0; g < STEPS; g++) begin : g_row
    for (genvar k = 0; k < NumPts; k++) begin : g_col
      assign wtab[g][k] = bern(g, k);
    end
  end

  // Sequencer
  pts_t            cur;
  logic            run;
  logic [CntW-1:0] cnt;
  logic            at_last;

  assign at_last = (cnt == CntW'(STEPS - 1));
  assign pop     = !stat.empty && (!run || at_last);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (pop) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      if (at_last) begin
        run <= 1'b0;
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Stage 1: weight lookup
  pts_t                 s1_pts;
  logic [WeightW-1:0]   s1_w [NumPts];
  logic [CntW-1:0]      s1_idx;
  logic                 s1_last;
  logic                 s1_valid;

  always_ff @(posedge clk) begin
    s1_pts  <= cur;
    s1_idx  <= cnt;
    s1_last <= at_last;
    for (int k = 0; k < NumPts; k++) begin
      s1_w[k] <= wtab[cnt][k];
    end
  end

  // Stage 2: products
  logic signed [ProdW-1:0] s2_px [NumPts];
  logic signed [ProdW-1:0] s2_py [NumPts];
  logic [CntW-1:0]         s2_idx;
  logic                    s2_last;
  logic                    s2_valid;
  coord_t                  ptx [NumPts];
  coord_t                  pty [NumPts];

  assign ptx[0] = s1_pts.p0_x;
  assign ptx[1] = s1_pts.p1_x;
  assign ptx[2] = s1_pts.p2_x;
  assign ptx[3] = s1_pts.p3_x;
  assign pty[0] = s1_pts.p0_y;
  assign pty[1] = s1_pts.p1_y;
  assign pty[2] = s1_pts.p2_y;
  assign pty[3] = s1_pts.p3_y;

  always_ff @(posedge clk) begin
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    for (int k = 0; k < NumPts; k++) begin
      s2_px[k] <= ProdW'(ptx[k]) * ProdW'($signed({1'b0, s1_w[k]}));
      s2_py[k] <= ProdW'(pty[k]) * ProdW'($signed({1'b0, s1_w[k]}));
    end
  end

  // Stage 3: sum, round, saturate
  logic signed [SumW-1:0]   sum_x;
  logic signed [SumW-1:0]   sum_y;
  logic signed [RoundW-1:0] q_x;
  logic signed [RoundW-1:0] q_y;
  logic signed [SumW-1:0]   t_x;
  logic signed [SumW-1:0]   t_y;

  always_comb begin
    sum_x = RoundHalf;
    sum_y = RoundHalf;
    for (int k = 0; k < NumPts; k++) begin
      sum_x = sum_x + SumW'(s2_px[k]);
      sum_y = sum_y + SumW'(s2_py[k]);
    end
    t_x = sum_x >>> OShift;
    t_y = sum_y >>> OShift;
    q_x = t_x[RoundW-1:0];
    q_y = t_y[RoundW-1:0];
  end

  function automatic logic signed [OutW-1:0] sat(logic signed [RoundW-1:0] q);
    priority if (q > OutMax) begin
      return OutMax[OutW-1:0];
    end else if (q < OutMin) begin
      return OutMin[OutW-1:0];
    end else begin
      return q[OutW-1:0];
    end
  endfunction

  logic [CntW+IdxW-1:0] idx_ext;
  assign idx_ext = (CntW + IdxW)'(s2_idx);

  always_ff @(posedge clk) begin
    curve_x      <= sat(q_x);
    curve_y      <= sat(q_y);
    sample_index <= idx_ext[IdxW-1:0];
    last_sample  <= s2_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      s1_valid <= run;
      s2_valid <= s1_valid;
      valid    <= s2_valid;
    end
  end

endmodule

@@ sv/cubic_bezier_sampler.sv @@
// Cubic Bezier sampler. Each request carries four signed 10-bit control points and
// yields STEPS sample points, u = i/STEPS for i = 0 .. STEPS-1, one point per cycle
// on curve_x / curve_y (8 fraction bits, saturated to 18 bits), with sample_index
// (i modulo 32) and last_sample marking the final point. valid marks each point
// for exactly one cycle and the receiver cannot stall it. The sample sequencer
// issues one point per cycle and pops the next queued request as it issues the
// last point of a run, so runs follow back to back; each point then passes the
// weight lookup, products and sum/round/saturate stages. A two-entry request queue
// lets start be taken while a run is in progress; busy is high only while it is full.
module cubic_bezier_sampler #(
  parameter int STEPS = cbs_pkg::StepsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cbs_pkg::CoordW-1:0]  p0_x,
  input  logic signed [cbs_pkg::CoordW-1:0]  p0_y,
  input  logic signed [cbs_pkg::CoordW-1:0]  p1_x,
  input  logic signed [cbs_pkg::CoordW-1:0]  p1_y,
  input  logic signed [cbs_pkg::CoordW-1:0]  p2_x,
  input  logic signed [cbs_pkg::CoordW-1:0]  p2_y,
  input  logic signed [cbs_pkg::CoordW-1:0]  p3_x,
  input  logic signed [cbs_pkg::CoordW-1:0]  p3_y,
  output logic                               valid,
  output logic signed [cbs_pkg::OutW-1:0]    curve_x,
  output logic signed [cbs_pkg::OutW-1:0]    curve_y,
  output logic        [cbs_pkg::IdxW-1:0]    sample_index,
  output logic                               last_sample
);
  import cbs_pkg::*;

  pts_t   req;
  pts_t   head;
  qstat_t stat;
  logic   push;
  logic   pop;

  assign req  = '{p0_x: p0_x, p0_y: p0_y, p1_x: p1_x, p1_y: p1_y,
                  p2_x: p2_x, p2_y: p2_y, p3_x: p3_x, p3_y: p3_y};
  assign busy = stat.full;
  assign push = start && !stat.full;

  cbs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (req),
    .pop  (pop),
    .dout (head),
    .stat (stat)
  );

  cbs_back #(
    .STEPS (STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .valid        (valid),
    .curve_x      (curve_x),
    .curve_y      (curve_y),
    .sample_index (sample_index),
    .last_sample  (last_sample)
  );

endmodule
